// ===== rtl/core/vphp_pkg.sv =====
`default_nettype none

package vphp_pkg;

   // result field widths
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int ID_W     = 24;
   localparam int STATUS_W = 2;

   // results per accepted byte and index into the result buffer
   localparam int MAX_RES  = 5;
   localparam int RES_W    = 3;

   // parser phases
   localparam logic [2:0] PH_FIXED = 3'd0;
   localparam logic [2:0] PH_VAR0  = 3'd1;
   localparam logic [2:0] PH_VAR1  = 3'd2;
   localparam logic [2:0] PH_VAR2  = 3'd3;
   localparam logic [2:0] PH_BODY  = 3'd4;
   localparam logic [2:0] PH_SKIP  = 3'd5;

   // fixed header layout: four count bytes, three id bytes, two length bytes
   localparam logic [3:0] FIX_ID_START  = 4'd4;
   localparam logic [3:0] FIX_LEN_START = 4'd7;
   localparam logic [3:0] FIX_LAST      = 4'd8;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_UNIMPL = 2'd1;
   localparam logic [1:0] ST_BAD    = 2'd2;

   // varint fields
   localparam logic [7:0] VARINT_MORE = 8'h80;
   localparam logic [7:0] VARINT_DATA = 8'h7f;

   // header limits and markers
   localparam logic [31:0] PACKED_ONE  = 32'd1;
   localparam logic [31:0] MAX_HEADERS = 32'd3;
   localparam logic [7:0]  XIPH_MARKER = 8'd2;
   localparam logic [7:0]  LACE_FULL   = 8'd255;
   localparam logic [16:0] SEEN_MAX    = 17'h1ffff;

   // x / 255 for 16-bit x: (x * 0x8081) >> 23, exact over the whole range
   localparam logic [15:0] RECIP_255   = 16'h8081;
   localparam int          RECIP_SHIFT = 23;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [COUNT_W-1:0]  out_count;
      logic [STATUS_W-1:0] status;
      logic                blob_done;
   } res_type;

endpackage

`default_nettype wire

// ===== rtl/core/vorbis_packed_header_parser.sv =====
`default_nettype none

// Packed header parser: takes a decoded packed header blob one byte per
// transfer on the req_ channel (req_blob_last marks the final byte) and
// gives Xiph extradata results on the rsp_ channel. Each result asks for
// rsp_out_count copies of rsp_out_byte; a count of 0 is a status-only result.
// rsp_run_last marks the last result caused by one input byte, rsp_blob_done
// the result that ends the blob.
// Latency: the results of a byte appear on rsp_ the cycle after its transfer.
// Throughput: one byte per cycle while each byte gives at most one result
// (fixed bytes, varint bytes, body bytes). The byte closing a passing header
// gives three to five results, drained one per cycle from the result buffer;
// req_ready stays low until the last of them is being taken.
// A stall on rsp_ready holds the current result; a new byte is taken in the
// same cycle as the final pending result, so the two sides overlap.
// Reset clears the parser to the start of a blob, empties the result buffer
// and zeroes the stream identifier.
module vorbis_packed_header_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [vphp_pkg::BYTE_W-1:0]    req_in_byte,
   input  wire logic                           req_blob_last,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [vphp_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic [vphp_pkg::COUNT_W-1:0]        rsp_out_count,
   output logic [vphp_pkg::ID_W-1:0]           rsp_stream_id,
   output logic [vphp_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_blob_done,
   output logic                                rsp_run_last
);
   import vphp_pkg::*;

   // parser state
   logic [2:0]         phase_ff,   phase_in;
   logic [3:0]         fix_idx_ff, fix_idx_in;
   logic [31:0]        packed_ff,  packed_in;
   logic [ID_W-1:0]    sid_ff,     sid_in;
   logic [15:0]        blen_ff,    blen_in;
   logic [31:0]        acc_ff,     acc_in;
   logic [31:0]        htot_ff,    htot_in;
   logic [31:0]        flen_ff,    flen_in;
   logic [16:0]        seen_ff,    seen_in;
   logic [COUNT_W-1:0] fq_ff,      fq_in;
   logic [BYTE_W-1:0]  fr_ff,      fr_in;

   // result buffer
   res_type            res_ff [MAX_RES];
   res_type            res_in [MAX_RES];
   logic [ID_W-1:0]    rid_ff,     rid_in;
   logic [RES_W-1:0]   num_ff,     num_in;
   logic [RES_W-1:0]   ptr_ff,     ptr_in;

   logic               req_xfer;
   logic               rsp_xfer;
   logic               last_pending;

   // combinational parse terms
   logic [31:0]        acc_new;
   logic               vphase;
   logic               vdone;
   logic [15:0]        blen_eff;
   logic [31:0]        ht_eff;
   logic [31:0]        fl_eff;
   logic [31:0]        sl_eff;
   logic [15:0]        blen_left;
   logic               bad_count;
   logic               bad_len;
   logic               do_finish;
   logic [31:0]        div_prod;
   logic [COUNT_W-1:0] div_q;
   logic [16:0]        div_qx;
   logic [BYTE_W-1:0]  div_r;
   logic [COUNT_W-1:0] sq;
   logic [BYTE_W-1:0]  sr;
   logic [16:0]        seen_inc;

   // handshake: take a byte when the buffer is empty or its last result leaves
   assign rsp_valid    = (ptr_ff != num_ff);
   assign last_pending = rsp_valid && (ptr_ff == num_ff - RES_W'(1));
   assign req_ready    = !rsp_valid || (rsp_ready && last_pending);
   assign req_xfer     = req_valid && req_ready;
   assign rsp_xfer     = rsp_valid && rsp_ready;

   // varint accumulation and header values as the checks see them
   assign acc_new  = {acc_ff[24:0], 7'b0} | {24'b0, req_in_byte & VARINT_DATA};
   assign vphase   = (phase_ff == PH_VAR0) || (phase_ff == PH_VAR1) ||
                     (phase_ff == PH_VAR2);
   assign vdone    = (req_in_byte & VARINT_MORE) == 8'b0;
   assign blen_eff = (phase_ff == PH_FIXED) ? {blen_ff[7:0], req_in_byte} : blen_ff;
   assign ht_eff   = (phase_ff == PH_VAR0 && vdone) ? acc_new : htot_ff;
   assign fl_eff   = (phase_ff == PH_VAR1 && vdone) ? acc_new : flen_ff;
   assign sl_eff   = (phase_ff == PH_VAR2 && vdone) ? acc_new : 32'b0;

   assign blen_left = blen_eff - fl_eff[15:0];
   assign bad_count = (packed_ff != PACKED_ONE) || (ht_eff > MAX_HEADERS);
   assign bad_len   = (fl_eff > {16'b0, blen_eff}) ||
                      (sl_eff > {16'b0, blen_left}) ||
                      (req_blob_last && (blen_eff != 16'b0));

   // header ends here: at the last fixed byte with blob end, at the third
   // varint, or when the blob ends inside a varint
   assign do_finish = ((phase_ff == PH_FIXED) && (fix_idx_ff >= FIX_LAST) &&
                       req_blob_last) ||
                      (vphase && vdone && ((phase_ff == PH_VAR2) || req_blob_last)) ||
                      (vphase && !vdone && req_blob_last);

   // shared divide by 255 of a completed length (only the low 16 bits matter
   // whenever the lengths pass the checks)
   assign div_prod = acc_new[15:0] * RECIP_255;
   assign div_q    = div_prod[31:RECIP_SHIFT];
   assign div_qx   = {div_q, 8'b0} - {8'b0, div_q};
   assign div_r    = acc_new[7:0] - div_qx[7:0];
   assign sq       = (phase_ff == PH_VAR2 && vdone) ? div_q : '0;
   assign sr       = (phase_ff == PH_VAR2 && vdone) ? div_r : '0;

   assign seen_inc = (seen_ff < SEEN_MAX) ? seen_ff + 17'd1 : seen_ff;

   // next parser state and result list for the byte on req_
   always_comb begin
      logic                clr;
      logic [RES_W-1:0]    k;
      logic [STATUS_W-1:0] st;

      phase_in   = phase_ff;
      fix_idx_in = fix_idx_ff;
      packed_in  = packed_ff;
      sid_in     = sid_ff;
      blen_in    = blen_ff;
      acc_in     = acc_ff;
      htot_in    = htot_ff;
      flen_in    = flen_ff;
      seen_in    = seen_ff;
      fq_in      = fq_ff;
      fr_in      = fr_ff;
      rid_in     = sid_ff;
      clr        = 1'b0;
      k          = '0;
      st         = ST_OK;
      for (int j = 0; j < MAX_RES; j++) begin
         res_in[j] = '0;
      end

      unique case (phase_ff) inside
         PH_FIXED: begin
            if (fix_idx_ff < FIX_ID_START) begin
               packed_in = {packed_ff[23:0], req_in_byte};
            end else if (fix_idx_ff < FIX_LEN_START) begin
               sid_in = {sid_ff[15:0], req_in_byte};
               rid_in = {sid_ff[15:0], req_in_byte};
            end else begin
               blen_in = {blen_ff[7:0], req_in_byte};
            end
            if (fix_idx_ff >= FIX_LAST) begin
               fix_idx_in = '0;
               phase_in   = PH_VAR0;
               acc_in     = '0;
            end else if (req_blob_last) begin
               // blob cut inside the fixed bytes
               res_in[0] = '{out_byte: '0, out_count: '0, status: ST_BAD,
                             blob_done: 1'b1};
               rid_in    = '0;
               k         = RES_W'(1);
               clr       = 1'b1;
            end else begin
               fix_idx_in = fix_idx_ff + 4'd1;
            end
         end
         PH_VAR0, PH_VAR1, PH_VAR2: begin
            if (vdone) begin
               if (phase_ff == PH_VAR0) begin
                  htot_in = acc_new;
               end else if (phase_ff == PH_VAR1) begin
                  flen_in = acc_new;
                  fq_in   = div_q;
                  fr_in   = div_r;
               end
               acc_in   = '0;
               phase_in = phase_ff + 3'd1;
            end else if (req_blob_last) begin
               acc_in = '0;
            end else begin
               acc_in = acc_new;
            end
         end
         PH_BODY: begin
            seen_in = seen_inc;
            if (req_blob_last) begin
               st  = (seen_inc == {1'b0, blen_ff}) ? ST_OK : ST_BAD;
               clr = 1'b1;
            end
            res_in[0] = '{out_byte: req_in_byte, out_count: COUNT_W'(1), status: st,
                          blob_done: req_blob_last};
            k = RES_W'(1);
         end
         PH_SKIP: begin
            clr = req_blob_last;
         end
         default: begin
            phase_in = PH_FIXED;
         end
      endcase

      // header checks and Xiph lacing
      if (do_finish) begin
         if (bad_count || bad_len) begin
            res_in[0] = '{out_byte: '0, out_count: '0,
                          status: bad_count ? ST_UNIMPL : ST_BAD, blob_done: 1'b1};
            k = RES_W'(1);
            if (req_blob_last) begin
               clr = 1'b1;
            end else begin
               phase_in = PH_SKIP;
            end
         end else begin
            res_in[0] = '{out_byte: XIPH_MARKER, out_count: COUNT_W'(1), status: ST_OK,
                          blob_done: 1'b0};
            k = RES_W'(1);
            if (fq_ff != '0) begin
               res_in[k] = '{out_byte: LACE_FULL, out_count: fq_ff, status: ST_OK,
                             blob_done: 1'b0};
               k = k + RES_W'(1);
            end
            res_in[k] = '{out_byte: fr_ff, out_count: COUNT_W'(1), status: ST_OK,
                          blob_done: 1'b0};
            k = k + RES_W'(1);
            if (sq != '0) begin
               res_in[k] = '{out_byte: LACE_FULL, out_count: sq, status: ST_OK,
                             blob_done: 1'b0};
               k = k + RES_W'(1);
            end
            res_in[k] = '{out_byte: sr, out_count: COUNT_W'(1), status: ST_OK,
                          blob_done: 1'b0};
            k = k + RES_W'(1);
            if (req_blob_last) begin
               res_in[k - RES_W'(1)].blob_done = 1'b1;
               clr = 1'b1;
            end else begin
               phase_in = PH_BODY;
               seen_in  = '0;
            end
         end
      end

      // blob end: back to the fixed bytes, identifier kept
      if (clr) begin
         phase_in   = PH_FIXED;
         fix_idx_in = '0;
         packed_in  = '0;
         blen_in    = '0;
         acc_in     = '0;
         htot_in    = '0;
         flen_in    = '0;
         seen_in    = '0;
         fq_in      = '0;
         fr_in      = '0;
      end

      num_in = k;
   end

   // buffer pointers
   always_comb begin
      ptr_in = ptr_ff;
      if (rsp_xfer) begin
         ptr_in = ptr_ff + RES_W'(1);
      end
      if (req_xfer) begin
         ptr_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FIXED;
         fix_idx_ff <= '0;
         packed_ff  <= '0;
         sid_ff     <= '0;
         blen_ff    <= '0;
         acc_ff     <= '0;
         htot_ff    <= '0;
         flen_ff    <= '0;
         seen_ff    <= '0;
         fq_ff      <= '0;
         fr_ff      <= '0;
         num_ff     <= '0;
         ptr_ff     <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (req_xfer) begin
            phase_ff   <= phase_in;
            fix_idx_ff <= fix_idx_in;
            packed_ff  <= packed_in;
            sid_ff     <= sid_in;
            blen_ff    <= blen_in;
            acc_ff     <= acc_in;
            htot_ff    <= htot_in;
            flen_ff    <= flen_in;
            seen_ff    <= seen_in;
            fq_ff      <= fq_in;
            fr_ff      <= fr_in;
            num_ff     <= num_in;
         end
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rid_ff <= rid_in;
         for (int j = 0; j < MAX_RES; j++) begin
            res_ff[j] <= res_in[j];
         end
      end
   end

   // output selection
   assign rsp_out_byte  = res_ff[ptr_ff].out_byte;
   assign rsp_out_count = res_ff[ptr_ff].out_count;
   assign rsp_status    = res_ff[ptr_ff].status;
   assign rsp_blob_done = res_ff[ptr_ff].blob_done;
   assign rsp_stream_id = rid_ff;
   assign rsp_run_last  = last_pending;

   // checks
   a_buf_depth: assert property (@(posedge clock) disable iff (reset)
      (num_ff <= RES_W'(MAX_RES)) && (ptr_ff <= num_ff))
      else $error("result buffer pointer out of range");

   a_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && rsp_valid) |-> (rsp_ready && last_pending))
      else $error("byte taken while results still pending");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_blob_done) |-> rsp_run_last)
      else $error("blob end result is not the last of its byte");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_count == '0) |-> (rsp_blob_done && rsp_status != ST_OK))
      else $error("status-only result without blob end");

   a_fix_idx: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_FIXED) |-> (fix_idx_ff == '0))
      else $error("fixed byte index left set outside fixed phase");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !req_xfer) |=> (ptr_ff == $past(ptr_ff) + RES_W'(1)))
      else $error("result pointer did not advance");

endmodule

`default_nettype wire
